// ----- sv/lzl_pkg.sv -----
// lzl_pkg: shared constants, types and helpers for the lazy-delete list.
// No dependencies; used by lzl_ram users, lzl_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lzl_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = ADDR_W + 1;
    localparam int VAL_W   = 64;

    localparam logic [VAL_W-1:0] INFINITY = 64'h7FF0_0000_0000_0000;

    typedef enum logic [2:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_BACK  = 3'd1,
        CMD_DEL_FIRST = 3'd2,
        CMD_DEL_LAST  = 3'd3,
        CMD_DEL_NTH   = 3'd4,
        CMD_RECALL    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_RECALL = 2'd3
    } status_t;

    typedef struct packed {
        logic             marked;
        logic [CNT_W-1:0] order;
        logic [VAL_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // circular slot of a rank counted from the front
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                  input logic [ADDR_W-1:0] rank);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, front} + {1'b0, rank};
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/lzl_ram.sv -----
// lzl_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lzl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH_N = 4,
    parameter int AW     = 2
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH_N];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/lzl_ctrl.sv -----
// lzl_ctrl: command sequencer; walks the entry RAM for search, recall, compaction.
// Depends on lzl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzl_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [2:0]              cmd,
    input  wire logic [63:0]             value_in,
    input  wire logic [6:0]              position,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [63:0]                  value_out,
    output logic [1:0]                   status,
    output logic [6:0]                   live_count,
    output logic [6:0]                   marked_count,
    output lzl_pkg::ram_req_t            ram_req,
    input  wire logic [lzl_pkg::ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        M_SINGLE,
        M_FIRST,
        M_LAST,
        M_NTH,
        M_RECALL,
        M_COMPACT
    } mode_t;

    state_t                        state_reg, state_next;
    mode_t                         mode_reg, mode_next;
    logic [lzl_pkg::CNT_W-1:0]     i_reg, i_next;
    logic [lzl_pkg::CNT_W-1:0]     w_reg, w_next;
    logic [lzl_pkg::CNT_W-1:0]     seen_reg, seen_next;
    logic [lzl_pkg::ADDR_W-1:0]    front_reg, front_next;
    logic [lzl_pkg::CNT_W-1:0]     stored_reg, stored_next;
    logic [lzl_pkg::CNT_W-1:0]     mt_reg, mt_next;
    logic [6:0]                    pos_reg, pos_next;
    logic [63:0]                   res_reg, res_next;
    lzl_pkg::status_t              st_reg, st_next;
    logic                          ov_reg, ov_next;
    logic [63:0]                   vo_reg, vo_next;
    logic [1:0]                    so_reg, so_next;
    logic [6:0]                    lc_reg, lc_next;
    logic [6:0]                    mc_reg, mc_next;

    lzl_pkg::entry_t               rd_entry;
    logic [lzl_pkg::CNT_W-1:0]     live;
    logic [lzl_pkg::CNT_W-1:0]     mt_inc;
    logic [lzl_pkg::CNT_W-1:0]     last_i;
    logic [lzl_pkg::ADDR_W-1:0]    cur_slot;
    logic                          hit;

    assign rd_entry = lzl_pkg::entry_t'(ram_rdata);
    assign live     = stored_reg - mt_reg;
    assign mt_inc   = mt_reg + 1'b1;
    assign last_i   = stored_reg - 1'b1;
    assign cur_slot = lzl_pkg::slot_of(front_reg, i_reg[lzl_pkg::ADDR_W-1:0]);

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign value_out    = vo_reg;
    assign status       = so_reg;
    assign live_count   = lc_reg;
    assign marked_count = mc_reg;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        i_next      = i_reg;
        w_next      = w_reg;
        seen_next   = seen_reg;
        front_next  = front_reg;
        stored_next = stored_reg;
        mt_next     = mt_reg;
        pos_next    = pos_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        ov_next     = ov_reg && out_stall;
        vo_next     = vo_reg;
        so_next     = so_reg;
        lc_next     = lc_reg;
        mc_next     = mc_reg;
        hit         = 1'b0;

        ram_req.we    = 1'b0;
        ram_req.waddr = cur_slot;
        ram_req.wdata = '{marked: 1'b0, order: '0, value: rd_entry.value};
        ram_req.raddr = cur_slot;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next   = lzl_pkg::INFINITY;
                    st_next    = lzl_pkg::ST_DONE;
                    pos_next   = position;
                    seen_next  = '0;
                    i_next     = '0;
                    state_next = S_FINISH;
                    case (cmd)
                        lzl_pkg::CMD_ADD_FRONT, lzl_pkg::CMD_ADD_BACK:
                        begin
                            if (stored_reg >= lzl_pkg::CNT_W'(lzl_pkg::DEPTH))
                            begin
                                st_next = lzl_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.wdata = '{marked: 1'b0, order: '0, value: value_in};
                                if (cmd == lzl_pkg::CMD_ADD_FRONT)
                                begin
                                    front_next = (front_reg == '0) ?
                                        lzl_pkg::ADDR_W'(lzl_pkg::DEPTH - 1) :
                                        front_reg - 1'b1;
                                    ram_req.waddr = front_next;
                                end
                                else
                                begin
                                    ram_req.waddr = lzl_pkg::slot_of(front_reg,
                                        stored_reg[lzl_pkg::ADDR_W-1:0]);
                                end
                                stored_next = stored_reg + 1'b1;
                            end
                        end
                        lzl_pkg::CMD_DEL_FIRST, lzl_pkg::CMD_DEL_LAST, lzl_pkg::CMD_DEL_NTH:
                        begin
                            if (stored_reg == '0)
                            begin
                                st_next = lzl_pkg::ST_NOT_FOUND;
                            end
                            else if (stored_reg == lzl_pkg::CNT_W'(1) &&
                                     (cmd != lzl_pkg::CMD_DEL_NTH || position == 7'd1))
                            begin
                                mode_next  = M_SINGLE;
                                state_next = S_RD;
                            end
                            else if (cmd == lzl_pkg::CMD_DEL_NTH &&
                                     (position == 7'd0 || 32'(position) > 32'(live)))
                            begin
                                st_next = lzl_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_RD;
                                case (cmd)
                                    lzl_pkg::CMD_DEL_FIRST: mode_next = M_FIRST;
                                    lzl_pkg::CMD_DEL_LAST:
                                    begin
                                        mode_next = M_LAST;
                                        i_next    = last_i;
                                    end
                                    default: mode_next = M_NTH;
                                endcase
                            end
                        end
                        lzl_pkg::CMD_RECALL:
                        begin
                            if (mt_reg == '0)
                            begin
                                st_next = lzl_pkg::ST_NO_RECALL;
                            end
                            else
                            begin
                                mode_next  = M_RECALL;
                                state_next = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_RD;
                case (mode_reg)
                    M_SINGLE:
                    begin
                        res_next    = rd_entry.value;
                        stored_next = '0;
                        state_next  = S_FINISH;
                    end
                    M_FIRST, M_LAST, M_NTH:
                    begin
                        if (!rd_entry.marked)
                        begin
                            seen_next = seen_reg + 1'b1;
                            hit = (mode_reg != M_NTH) || (32'(seen_next) == 32'(pos_reg));
                        end
                        if (hit)
                        begin
                            res_next      = rd_entry.value;
                            ram_req.we    = 1'b1;
                            ram_req.wdata = '{marked: 1'b1, order: mt_inc,
                                              value: rd_entry.value};
                            mt_next       = mt_inc;
                            if ({mt_inc, 1'b0} > {1'b0, stored_reg})
                            begin
                                mode_next = M_COMPACT;
                                i_next    = '0;
                                w_next    = '0;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        else if (mode_reg == M_LAST ? (i_reg == '0) : (i_reg == last_i))
                        begin
                            st_next    = lzl_pkg::ST_NOT_FOUND;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            i_next = (mode_reg == M_LAST) ? i_reg - 1'b1 : i_reg + 1'b1;
                        end
                    end
                    M_RECALL:
                    begin
                        if (rd_entry.marked && rd_entry.order == mt_reg)
                        begin
                            res_next   = rd_entry.value;
                            ram_req.we = 1'b1;
                            mt_next    = mt_reg - 1'b1;
                            state_next = S_FINISH;
                        end
                        else if (i_reg == last_i)
                        begin
                            st_next    = lzl_pkg::ST_NO_RECALL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    M_COMPACT:
                    begin
                        if (!rd_entry.marked)
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = lzl_pkg::slot_of(front_reg,
                                                w_reg[lzl_pkg::ADDR_W-1:0]);
                            w_next        = w_reg + 1'b1;
                        end
                        if (i_reg == last_i)
                        begin
                            stored_next = w_next;
                            mt_next     = '0;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_FINISH:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    vo_next    = res_reg;
                    so_next    = st_reg;
                    lc_next    = 7'(live);
                    mc_next    = 7'(mt_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= M_SINGLE;
            front_reg  <= '0;
            stored_reg <= '0;
            mt_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            front_reg  <= front_next;
            stored_reg <= stored_next;
            mt_reg     <= mt_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        w_reg    <= w_next;
        seen_reg <= seen_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        vo_reg   <= vo_next;
        so_reg   <= so_next;
        lc_reg   <= lc_next;
        mc_reg   <= mc_next;
    end

endmodule
`default_nettype wire

// ----- sv/lazy_delete_list_with_recall.sv -----
// lazy_delete_list_with_recall: top level; sequencer plus entry RAM.
// Depends on lzl_pkg, lzl_ram, lzl_ctrl.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to lzl_pkg::DEPTH 64-bit values held in a circular
// entry RAM (value, mark bit and mark number per entry). One transaction at
// a time: in_stall is high from acceptance until the result is loaded into
// the output register, which may still hold an earlier result while the
// next transaction is taken. Every RAM entry visited takes a read state
// (S_RD) and a check state (S_CHK), as the single read port is registered.
// Adds and unused commands go straight to the finish state; deletes and
// recall walk the entries one at a time, at most the stored count; a mark
// that leaves more marked than live entries adds a compaction pass over
// every stored entry. The mark count always equals the number of
// outstanding marks, so marked_count is read from a register rather than
// counted. No clearing pass after reset: every entry inside the stored
// range was written by an add first.
module lazy_delete_list_with_recall (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [63:0] value_in,
    input  wire logic [6:0]  position,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value_out,
    output logic [1:0]       status,
    output logic [6:0]       live_count,
    output logic [6:0]       marked_count
);

    lzl_pkg::ram_req_t              ram_req;
    logic [lzl_pkg::ENTRY_W-1:0]    ram_rdata;

    // sequencer: decode, search walks, mark/recall and compaction
    lzl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value_in     (value_in),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_out    (value_out),
        .status       (status),
        .live_count   (live_count),
        .marked_count (marked_count),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    // entry store
    lzl_ram #(
        .WIDTH   (lzl_pkg::ENTRY_W),
        .DEPTH_N (lzl_pkg::DEPTH),
        .AW      (lzl_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTH
    // compaction keeps marked entries from outnumbering live ones
    a_marks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (marked_count <= live_count))
        else $error("marked entries outnumber live entries");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(live_count) + 32'(marked_count) <= 32'(lzl_pkg::DEPTH)))
        else $error("stored count exceeds depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == lzl_pkg::ST_FULL) |->
            (32'(live_count) + 32'(marked_count) == 32'(lzl_pkg::DEPTH)))
        else $error("full status on a list that is not full");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted a transaction without going busy");
`endif

endmodule
`default_nettype wire
